### hdl/assert_macros.svh
// Assertion macros for the RTL of the voice volume block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_IMPLIES(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/vvpr_pkg.sv
// Types, constants and pan table function for the voice volume block.
package vvpr_pkg;

    localparam int unsigned NUM_STAGES = 7;

    // register indexes on the config port
    localparam logic CFG_SONG_VOL_LEFT  = 1'b0;
    localparam logic CFG_SONG_VOL_RIGHT = 1'b1;

    localparam logic signed [8:0] SONG_VOL_RESET = 9'sd127;

    // voice volume: product of four 7-bit values over 127^3, by reciprocal
    localparam int unsigned VVOL_DIV   = 32'h1F417F;
    localparam int unsigned VVOL_SHIFT = 49;
    localparam logic [63:0] VVOL_RECIP_W =
        ((64'd1 << VVOL_SHIFT) + 64'(VVOL_DIV) - 64'd1) / 64'(VVOL_DIV);
    localparam logic [28:0] VVOL_RECIP = VVOL_RECIP_W[28:0];

    // linear term: 22-bit product over 127^2, by reciprocal
    localparam int unsigned LIN_DIV   = 32'h3F01;
    localparam int unsigned LIN_SHIFT = 36;
    localparam logic [63:0] LIN_RECIP_W =
        ((64'd1 << LIN_SHIFT) + 64'(LIN_DIV) - 64'd1) / 64'(LIN_DIV);
    localparam logic [22:0] LIN_RECIP = LIN_RECIP_W[22:0];

    localparam logic [13:0] VOL_MAX    = 14'h3FFF;
    localparam logic [6:0]  GAIN_FULL  = 7'h7F;
    localparam logic [6:0]  GAIN_CTR   = 7'd120;
    localparam logic [6:0]  PAN_CENTRE = 7'h40;
    localparam logic [7:0]  SUM_LO     = 8'd65;
    localparam logic [7:0]  SUM_HI     = 8'd191;
    localparam logic [5:0]  RAMP_KNEE  = 6'd49;
    localparam logic [6:0]  RAMP_BASE  = 7'd96;

    typedef struct packed {
        logic [6:0] left;
        logic [6:0] right;
    } gains_t;

    // gain of the ramping side for an index of 1..63
    function automatic logic [6:0] ramp_gain(input logic [5:0] i);
        logic [6:0] g;
        if (i <= RAMP_KNEE) begin
            g = 7'((7'(i) - 7'd1) << 1);
        end else begin
            g = RAMP_BASE + 7'(i - RAMP_KNEE);
        end
        return g;
    endfunction

    // rule-built pan table, index 1..127
    function automatic gains_t pan_gains(input logic [6:0] idx);
        gains_t g;
        if (idx < PAN_CENTRE) begin
            g.left  = GAIN_FULL;
            g.right = ramp_gain(idx[5:0]);
        end else if (idx == PAN_CENTRE) begin
            g.left  = GAIN_CTR;
            g.right = GAIN_CTR;
        end else begin
            g.left  = ramp_gain(6'(8'd128 - 8'(idx)));
            g.right = GAIN_FULL;
        end
        return g;
    endfunction

endpackage

### hdl/voice_volume_pan_registers.sv
// Top level: voice volume and pan to left/right volume register values.
//
// Usage
//   s_ channel: one word per voice. s_tdata bits, lowest first:
//     channel_volume[6:0], expression[13:7], program_volume[20:14],
//     tone_volume[27:21], velocity[34:28], channel_pan[41:35],
//     tone_pan[49:42], zero fill [55:50].
//   m_ channel: one word per accepted input, in order. m_tdata holds
//     vol_left[13:0], vol_right[27:14], zero fill [31:28].
//   cfg_ channel: index 0 writes the left song pre-volume, index 1 the
//     right (9-bit signed); always ready, write only while no word is in
//     flight.
// Timing
//   Seven register stages (two 7x7 products, the 14x14 product, the 127^3
//   reciprocal multiply, velocity product, pre-volume product, the 127^2
//   reciprocal multiply and pan gain with saturation). One word per cycle
//   sustained while m_tready is high.
// Reset and stall
//   aresetn (synchronous, low) empties the pipeline and sets both
//   pre-volumes to 127. When m_tready is low, words close up behind the
//   held output; s_tready drops only once every stage is full.
module voice_volume_pan_registers
    import vvpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // ch_vol, expr, prog_vol, tone_vol, vel, ch_pan, tone_pan
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // vol_left, vol_right
);

`include "assert_macros.svh"

    // ---------------- configuration registers ----------------
    logic signed [8:0] song_vol_left_reg, song_vol_right_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            song_vol_left_reg  <= SONG_VOL_RESET;
            song_vol_right_reg <= SONG_VOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SONG_VOL_LEFT:  song_vol_left_reg  <= cfg_data;
                CFG_SONG_VOL_RIGHT: song_vol_right_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or the stage after it moves on.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_tready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- input unpack ----------------
    logic [6:0] in_ch_vol, in_expr, in_prog_vol, in_tone_vol, in_vel, in_ch_pan;
    logic [7:0] in_tone_pan;

    assign in_ch_vol   = s_tdata[6:0];
    assign in_expr     = s_tdata[13:7];
    assign in_prog_vol = s_tdata[20:14];
    assign in_tone_vol = s_tdata[27:21];
    assign in_vel      = s_tdata[34:28];
    assign in_ch_pan   = s_tdata[41:35];
    assign in_tone_pan = s_tdata[49:42];

    // ---------------- stage 1: pair products, pan index ----------------
    logic [13:0] s1_p1_reg, s1_p2_reg, s1_p1_next, s1_p2_next;
    logic [6:0]  s1_vel_reg, s1_idx_reg, s1_idx_next;
    logic [6:0]  ch_pan_c, tone_pan_c;
    logic [7:0]  pan_sum, pan_sum_c;

    always_comb begin
        s1_p1_next = 14'(in_ch_vol) * 14'(in_expr);
        s1_p2_next = 14'(in_prog_vol) * 14'(in_tone_vol);

        ch_pan_c = (in_ch_pan == 7'd0) ? 7'd1 : in_ch_pan;
        if (in_tone_pan[7])            tone_pan_c = GAIN_FULL;
        else if (in_tone_pan == 8'd0)  tone_pan_c = 7'd1;
        else                           tone_pan_c = in_tone_pan[6:0];

        pan_sum = 8'(ch_pan_c) + 8'(tone_pan_c);
        if (pan_sum < SUM_LO)      pan_sum_c = SUM_LO;
        else if (pan_sum > SUM_HI) pan_sum_c = SUM_HI;
        else                       pan_sum_c = pan_sum;
        s1_idx_next = 7'(pan_sum_c - 8'(PAN_CENTRE));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_p1_reg  <= s1_p1_next;
            s1_p2_reg  <= s1_p2_next;
            s1_vel_reg <= in_vel;
            s1_idx_reg <= s1_idx_next;
        end
    end

    // ---------------- stage 2: four-way product, pan table ----------------
    logic [27:0] s2_prod_reg, s2_prod_next;
    logic [6:0]  s2_vel_reg;
    gains_t      s2_gain_reg, s2_gain_next;

    always_comb begin
        s2_prod_next = 28'(s1_p1_reg) * 28'(s1_p2_reg);
        s2_gain_next = pan_gains(s1_idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s2_prod_reg <= s2_prod_next;
            s2_vel_reg  <= s1_vel_reg;
            s2_gain_reg <= s2_gain_next;
        end
    end

    // ---------------- stage 3: divide by 127^3 ----------------
    logic [56:0] vvol_mul;
    logic [6:0]  s3_vvol_reg, s3_vvol_next, s3_vel_reg;
    gains_t      s3_gain_reg;

    always_comb begin
        vvol_mul     = 57'(s2_prod_reg) * 57'(VVOL_RECIP);
        s3_vvol_next = vvol_mul[VVOL_SHIFT +: 7];   // quotient is 0..127
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s3_vvol_reg <= s3_vvol_next;
            s3_vel_reg  <= s2_vel_reg;
            s3_gain_reg <= s2_gain_reg;
        end
    end

    // ---------------- stage 4: voice volume x velocity ----------------
    logic [13:0] s4_vv_reg, s4_vv_next;
    gains_t      s4_gain_reg;

    assign s4_vv_next = 14'(s3_vvol_reg) * 14'(s3_vel_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s4_vv_reg   <= s4_vv_next;
            s4_gain_reg <= s3_gain_reg;
        end
    end

    // ---------------- stage 5: song pre-volume per side ----------------
    // Zero or negative pre-volume forces a zero linear term.
    logic [7:0]  sv_left_pos, sv_right_pos;
    logic [21:0] s5_left_reg, s5_right_reg, s5_left_next, s5_right_next;
    gains_t      s5_gain_reg;

    always_comb begin
        sv_left_pos   = song_vol_left_reg[8]  ? 8'd0 : song_vol_left_reg[7:0];
        sv_right_pos  = song_vol_right_reg[8] ? 8'd0 : song_vol_right_reg[7:0];
        s5_left_next  = 22'(sv_left_pos)  * 22'(s4_vv_reg);
        s5_right_next = 22'(sv_right_pos) * 22'(s4_vv_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            s5_left_reg  <= s5_left_next;
            s5_right_reg <= s5_right_next;
            s5_gain_reg  <= s4_gain_reg;
        end
    end

    // ---------------- stage 6: divide by 127^2 ----------------
    logic [44:0] lin_left_mul, lin_right_mul;
    logic [7:0]  s6_left_reg, s6_right_reg, s6_left_next, s6_right_next;
    gains_t      s6_gain_reg;

    always_comb begin
        lin_left_mul  = 45'(s5_left_reg)  * 45'(LIN_RECIP);
        lin_right_mul = 45'(s5_right_reg) * 45'(LIN_RECIP);
        s6_left_next  = lin_left_mul[LIN_SHIFT +: 8];   // 0..255
        s6_right_next = lin_right_mul[LIN_SHIFT +: 8];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s6_left_reg  <= s6_left_next;
            s6_right_reg <= s6_right_next;
            s6_gain_reg  <= s5_gain_reg;
        end
    end

    // ---------------- stage 7: pan gain, saturate, output register ----------------
    logic [14:0] scaled_left, scaled_right;
    logic [13:0] out_left_reg, out_right_reg, out_left_next, out_right_next;

    always_comb begin
        scaled_left    = 15'(s6_left_reg)  * 15'(s6_gain_reg.left);
        scaled_right   = 15'(s6_right_reg) * 15'(s6_gain_reg.right);
        out_left_next  = (scaled_left  > 15'(VOL_MAX)) ? VOL_MAX : scaled_left[13:0];
        out_right_next = (scaled_right > 15'(VOL_MAX)) ? VOL_MAX : scaled_right[13:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {4'd0, out_right_reg, out_left_reg};

    // ---------------- assertions ----------------
    // Input back-pressure only ever comes from a stalled, full output.
    `ASSERT_IMPLIES(a_stall_source, !s_tready, m_tvalid && !m_tready)
    // With the output stage empty nothing can block the input.
    `ASSERT_IMPLIES(a_empty_ready, !vld_reg[NUM_STAGES-1], s_tready)
    // An accepted word always lands in the first stage.
    `ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, vld_reg[0])

endmodule

### dv/voice_volume_pan_registers_test.sv
// Self-checking testbench for the voice volume and pan register block.
module voice_volume_pan_registers_test
    import vvpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One voice as it sits in s_tdata: channel_volume in the lowest bits,
    // tone_pan in the highest, 50 bits in all.
    typedef struct packed {
        logic [7:0] tone_pan;
        logic [6:0] channel_pan;
        logic [6:0] velocity;
        logic [6:0] tone_volume;
        logic [6:0] program_volume;
        logic [6:0] expression;
        logic [6:0] channel_volume;
    } voice_t;

    // One result word, vol_left in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [13:0] right;
        logic [13:0] left;
    } vol_pair_t;

    // receiver stall patterns
    typedef enum logic [1:0] {RX_STEADY, RX_PATCHY, RX_SPARSE} rx_mode_t;

    localparam int unsigned VOICE_DIV  = 32'h1F417F;  // 127^3
    localparam int unsigned LEVEL_DIV  = 32'h3F01;    // 127^2
    localparam int unsigned LEVEL_MAX  = 32'h3FFF;
    localparam int unsigned PAN_MID    = 64;
    localparam int unsigned KNEE       = 49;
    localparam int unsigned MAX_PRINTS = 40;

    // DUT inputs, all known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = CFG_SONG_VOL_LEFT;
    logic [8:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [55:0] s_tdata   = '0;   // ch_vol, expr, prog_vol, tone_vol, vel, ch_pan, tone_pan
    logic        m_tready  = 1'b0;
    // DUT outputs
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;          // vol_left, vol_right

    // Shadow copy of the two pre-volume registers
    logic signed [8:0] song_left_vol  = SONG_VOL_RESET;
    logic signed [8:0] song_right_vol = SONG_VOL_RESET;

    voice_t    pending_voices[$];   // words waiting for the driver
    vol_pair_t predicted_vols[$];   // expected results, oldest first
    vol_pair_t expected_pair;
    int        error_count = 0;

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;
    // receiver state
    rx_mode_t rx_mode        = RX_STEADY;
    int       rx_segment_left = 0;
    int       hold_left       = 0;
    int       rx_words        = 0;

    voice_volume_pan_registers dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Gain of the side that ramps down, for a pan position of 1..63:
    // steps of two up to the knee, then steps of one.
    function automatic int unsigned ramp_level(int unsigned pos);
        return pos <= KNEE ? 2 * (pos - 1) : 96 + (pos - KNEE);
    endfunction

    // One side: pre-volume times voice volume times velocity over 127^2,
    // nothing for a pre-volume of zero or below, then gain and saturation.
    function automatic logic [13:0] side_level(int pre_vol, int unsigned voice_vol,
                                               int unsigned vel, int unsigned gain);
        int unsigned lin;
        int unsigned scaled;
        if (pre_vol <= 0)
            return '0;
        lin    = (int'(pre_vol) * voice_vol * vel) / LEVEL_DIV;
        scaled = lin * gain;
        return scaled > LEVEL_MAX ? 14'(LEVEL_MAX) : 14'(scaled);
    endfunction

    function automatic vol_pair_t predict_volumes(voice_t v);
        int unsigned voice_vol;
        int unsigned ch_pan;
        int unsigned tn_pan;
        int unsigned pan_sum;
        int unsigned pos;
        int unsigned gain_l;
        int unsigned gain_r;
        vol_pair_t   res;
        voice_vol = (32'(v.channel_volume) * v.expression * v.program_volume
                     * v.tone_volume) / VOICE_DIV;
        ch_pan = (v.channel_pan == 0) ? 1 : v.channel_pan;
        tn_pan = (v.tone_pan > 127) ? 127 : ((v.tone_pan == 0) ? 1 : v.tone_pan);
        pan_sum = ch_pan + tn_pan;
        if (pan_sum < 65)  pan_sum = 65;
        if (pan_sum > 191) pan_sum = 191;
        pos = pan_sum - PAN_MID;            // 1..127
        if (pos < PAN_MID) begin
            gain_l = 127;
            gain_r = ramp_level(pos);
        end else if (pos == PAN_MID) begin
            gain_l = 120;
            gain_r = 120;
        end else begin
            gain_l = ramp_level(128 - pos);
            gain_r = 127;
        end
        res.left  = side_level(int'(song_left_vol),  voice_vol, v.velocity, gain_l);
        res.right = side_level(int'(song_right_vol), voice_vol, v.velocity, gain_r);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps; the next word is
    // held steady until taken. The expectation is formed at acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_vols.push_back(predict_volumes(pending_voices.pop_front()));
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long unbroken stream, otherwise short bursts
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 8);
                    end
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_voices.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pending_voices[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: segments of steady, patchy and sparse ready, and twice a
    // long hold-off so the pipeline fills and s_tready drops.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready        <= 1'b0;
            rx_segment_left = 0;
            hold_left       = 0;
            rx_words        = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_words++;
                if (rx_words == 75 || rx_words == 200)
                    hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_segment_left <= 0) begin
                    rx_mode         = rx_mode_t'($urandom_range(0, 2));
                    rx_segment_left = $urandom_range(1, 40);
                end
                rx_segment_left--;
                case (rx_mode)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_PATCHY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each word taken is checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_vols.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            end else begin
                expected_pair = predicted_vols.pop_front();
                if (m_tdata[13:0] !== expected_pair.left)
                    report_mismatch($sformatf("vol_left %h, expected %h",
                                              m_tdata[13:0], expected_pair.left));
                if (m_tdata[27:14] !== expected_pair.right)
                    report_mismatch($sformatf("vol_right %h, expected %h",
                                              m_tdata[27:14], expected_pair.right));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_voice(int cv, int ex, int pv, int tv, int vel, int cp, int tp);
        voice_t v;
        v.channel_volume = 7'(cv);
        v.expression     = 7'(ex);
        v.program_volume = 7'(pv);
        v.tone_volume    = 7'(tv);
        v.velocity       = 7'(vel);
        v.channel_pan    = 7'(cp);
        v.tone_pan       = 8'(tp);
        pending_voices.push_back(v);
    endtask

    // A quarter of the voices are loud so saturation and large gains show.
    task automatic queue_random_voices(int count);
        bit loud;
        int tp;
        for (int n = 0; n < count; n++) begin
            loud = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       tp = $urandom_range(128, 255);
                1:       tp = 0;
                default: tp = $urandom_range(0, 255);
            endcase
            queue_voice(loud ? $urandom_range(100, 127) : $urandom_range(0, 127),
                        loud ? $urandom_range(100, 127) : $urandom_range(0, 127),
                        loud ? $urandom_range(100, 127) : $urandom_range(0, 127),
                        loud ? $urandom_range(100, 127) : $urandom_range(0, 127),
                        loud ? $urandom_range(100, 127) : $urandom_range(0, 127),
                        ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 127),
                        tp);
        end
    endtask

    // Sender holds back until every expected word is home.
    task automatic wait_for_drain();
        while (pending_voices.size() != 0 || predicted_vols.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(logic index, logic signed [8:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_SONG_VOL_LEFT)
            song_left_vol = value;
        else
            song_right_vol = value;
    endtask

    // New pre-volumes only once the pipeline is empty, then a fresh batch.
    task automatic run_phase(logic signed [8:0] left, logic signed [8:0] right, int count);
        wait_for_drain();
        repeat (10) @(posedge aclk);
        write_register(CFG_SONG_VOL_LEFT, left);
        write_register(CFG_SONG_VOL_RIGHT, right);
        @(negedge aclk);
        queue_random_voices(count);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words at the reset pre-volumes.
        queue_voice(0, 0, 0, 0, 0, 0, 0);                // all zero, both pans lowest
        queue_voice(127, 127, 127, 127, 127, 127, 255);  // all full, both pans highest
        queue_voice(127, 127, 127, 127, 127, 0, 0);      // pan sum well under range
        queue_voice(127, 127, 127, 127, 127, 127, 127);  // pan sum well over range
        queue_voice(127, 127, 127, 127, 127, 64, 64);    // centre position
        queue_voice(127, 127, 127, 127, 127, 1, 112);    // right ramp at the knee
        queue_voice(127, 127, 127, 127, 127, 1, 113);    // just past the knee
        queue_voice(127, 127, 127, 127, 127, 63, 64);    // just left of centre
        queue_voice(127, 127, 127, 127, 127, 65, 64);    // just right of centre
        queue_voice(127, 127, 127, 127, 127, 127, 16);   // left ramp at the knee
        queue_voice(127, 127, 127, 127, 127, 127, 15);   // left ramp past the knee
        queue_voice(127, 127, 127, 127, 127, 64, 128);   // tone pan above 127
        queue_voice(127, 127, 127, 127, 127, 64, 1);     // tone pan of one
        queue_voice(127, 127, 127, 127, 127, 0, 64);     // channel pan zero
        queue_voice(127, 127, 127, 127, 0, 64, 64);      // no velocity
        queue_voice(1, 127, 127, 127, 127, 64, 64);      // voice volume of one
        queue_voice(127, 1, 127, 127, 127, 64, 64);
        queue_voice(127, 127, 1, 127, 127, 64, 64);
        queue_voice(127, 127, 127, 1, 127, 64, 64);
        queue_voice(85, 42, 21, 106, 85, 42, 170);       // alternating bit patterns
        queue_voice(42, 85, 106, 21, 42, 85, 85);
        queue_random_voices(40);

        // Pre-volume settings, extremes first: saturation on one side,
        // negative clamp on the other, zero, one, minus one, random, then reset value.
        run_phase(9'sd255, -9'sd128, 60);
        run_phase(-9'sd128, 9'sd255, 60);
        run_phase(9'sd0, 9'sd1, 60);
        run_phase(-9'sd1, 9'sd200, 60);
        run_phase(9'($urandom_range(0, 383) - 128), 9'($urandom_range(0, 383) - 128), 60);
        run_phase(SONG_VOL_RESET, SONG_VOL_RESET, 60);

        // Everything out, then a margin to catch any stray word.
        wait_for_drain();
        repeat (30) @(posedge aclk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
